// File: src/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types, widths and helpers of the gradient subregion accumulator.
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int unsigned GRAD_W   = 12;
	localparam int unsigned DIR_W    = 16;
	localparam int unsigned CTR_W    = 17;
	localparam int unsigned SIDE_W   = 5;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned PROD_W   = GRAD_W + DIR_W;
	localparam int unsigned PROJ_W   = PROD_W + 1;
	localparam int unsigned MAG_W    = PROD_W;
	localparam int unsigned SUM_W    = 35;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// One input sample as held in the first stage
	typedef struct packed {
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic signed [CTR_W-1:0]  center_x;
		logic signed [CTR_W-1:0]  center_y;
		logic        [SIDE_W-1:0] side;
		logic                     last;
	} sample_t;

	// Projected sample handed to the accumulator stage
	typedef struct packed {
		logic signed [PROJ_W-1:0] proj_along;
		logic signed [PROJ_W-1:0] proj_across;
		logic                     last;
		logic                     in_image;
	} proj_t;

	// Image bounds from the configuration registers
	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} bounds_t;

	// Add a magnitude to a sum, clamping at the top
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
			input logic [MAG_W-1:0] add);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W+1)'(add);
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

endpackage

// File: src/gsa_sample_if.sv
// ----------------------------------------------------------------------------
// gsa_sample_if
// Input channel: one gradient sample of a window per item.
// ----------------------------------------------------------------------------
interface gsa_sample_if;

	logic                                   valid;
	logic                                   ready;
	logic signed [gsa_pkg::GRAD_W-1:0]      grad_x;
	logic signed [gsa_pkg::GRAD_W-1:0]      grad_y;
	logic signed [gsa_pkg::DIR_W-1:0]       dir_x;
	logic signed [gsa_pkg::DIR_W-1:0]       dir_y;
	logic signed [gsa_pkg::CTR_W-1:0]       center_x;
	logic signed [gsa_pkg::CTR_W-1:0]       center_y;
	logic        [gsa_pkg::SIDE_W-1:0]      side;
	logic                                   last;

	modport source (output valid, grad_x, grad_y, dir_x, dir_y, center_x, center_y,
		side, last, input ready);
	modport sink (input valid, grad_x, grad_y, dir_x, dir_y, center_x, center_y,
		side, last, output ready);

endinterface

// File: src/gsa_result_if.sv
// ----------------------------------------------------------------------------
// gsa_result_if
// Output channel: the four window sums and the inside flag per item.
// ----------------------------------------------------------------------------
interface gsa_result_if;

	logic                          valid;
	logic                          ready;
	logic [gsa_pkg::SUM_W-1:0]     sum_pos_along;
	logic [gsa_pkg::SUM_W-1:0]     sum_neg_along;
	logic [gsa_pkg::SUM_W-1:0]     sum_pos_across;
	logic [gsa_pkg::SUM_W-1:0]     sum_neg_across;
	logic                          in_image;

	modport source (output valid, sum_pos_along, sum_neg_along, sum_pos_across,
		sum_neg_across, in_image, input ready);
	modport sink (input valid, sum_pos_along, sum_neg_along, sum_pos_across,
		sum_neg_across, in_image, output ready);

endinterface

// File: src/gradient_subregion_accumulator_core.sv
// ----------------------------------------------------------------------------
// gradient_subregion_accumulator_core
// Sums the along/across gradient projections of one square image window.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes one gradient sample per item, raster order, with last set
//   on the final sample of a window. Centre, side and direction travel with
//   every item; the bound check uses those of the last item.
//   result_ch gives one item per window: four saturating Q.14 sums and the
//   in_image flag (sums are zero when the window leaves the image).
//   cfg_we/cfg_index/cfg_data write image_width (index 0) and image_height
//   (index 1); write them only while no window is in flight.
// Timing:
//   One sample per cycle, sustained while no last sample is held back by a
//   waiting result. A last sample passes the input register, the projection
//   register and the result register in that order. Samples that are not last
//   never wait at the accumulators.
// Reset:
//   Clears the pipeline valids, the four accumulators and the result valid,
//   and loads the image size 640 x 480.
// Stall:
//   A held result blocks only the next last sample; while it waits in the
//   projection register the input register takes at most one more item,
//   then sample_ch.ready drops.
// ----------------------------------------------------------------------------
module gradient_subregion_accumulator_core #(
	parameter int unsigned MAX_SIDE = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gsa_pkg::DIM_W-1:0]          cfg_data,
	gsa_sample_if.sink                         sample_ch,
	gsa_result_if.source                       result_ch
);

	gsa_pkg::bounds_t  bounds_q;
	gsa_pkg::proj_t    proj_s2;
	logic              valid_s2;
	logic              take_s2;
	logic              adv_s2;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q.image_width  <= gsa_pkg::IMAGE_WIDTH_RST;
			bounds_q.image_height <= gsa_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gsa_pkg::CFG_IMAGE_WIDTH:  bounds_q.image_width  <= cfg_data;
				gsa_pkg::CFG_IMAGE_HEIGHT: bounds_q.image_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2 = !valid_s2 || take_s2;

	gsa_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.bounds    (bounds_q),
		.adv_s2    (adv_s2),
		.valid_s2  (valid_s2),
		.proj_s2   (proj_s2)
	);

	gsa_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.proj_s2   (proj_s2),
		.take_s2   (take_s2),
		.result_ch (result_ch)
	);

	// A window outside the image reports zero sums
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.in_image |->
			result_ch.sum_pos_along == '0 && result_ch.sum_neg_along == '0 &&
			result_ch.sum_pos_across == '0 && result_ch.sum_neg_across == '0)
		else $error("outside window with nonzero sums");

	// A consumed last item produces a result on the next cycle
	a_last_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && proj_s2.last && take_s2 |=> result_ch.valid)
		else $error("last item consumed without result");

	// Only a last item can wait in the projection stage
	a_only_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !take_s2 |-> proj_s2.last)
		else $error("non-last item stalled");

endmodule

// File: src/gsa_front.sv
// ----------------------------------------------------------------------------
// gsa_front
// Input register, gradient projection and window bound check.
// ----------------------------------------------------------------------------
module gsa_front #(
	parameter int unsigned MAX_SIDE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	gsa_sample_if.sink          sample_ch,
	input  gsa_pkg::bounds_t    bounds,
	input  logic                adv_s2,
	output logic                valid_s2,
	output gsa_pkg::proj_t      proj_s2
);

	logic                       valid_s1;
	gsa_pkg::sample_t           smp_s1;
	logic                       adv_s1;

	logic signed [gsa_pkg::PROD_W-1:0] gxdx, gydy, gydx, gxdy;
	logic signed [gsa_pkg::PROJ_W-1:0] along, across;

	logic signed [gsa_pkg::CTR_W+1:0]  diff_x, diff_y;
	logic        [14:0]                tl_x, tl_y;
	logic        [14:0]                far_x, far_y;
	logic                              side_ok, in_window;

	// Stage 1 empties or moves on when stage 2 can take it
	assign adv_s1          = !valid_s1 || adv_s2;
	assign sample_ch.ready = adv_s1;

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample_ch.valid) begin
			smp_s1.grad_x   <= sample_ch.grad_x;
			smp_s1.grad_y   <= sample_ch.grad_y;
			smp_s1.dir_x    <= sample_ch.dir_x;
			smp_s1.dir_y    <= sample_ch.dir_y;
			smp_s1.center_x <= sample_ch.center_x;
			smp_s1.center_y <= sample_ch.center_y;
			smp_s1.side     <= sample_ch.side;
			smp_s1.last     <= sample_ch.last;
		end
	end

	// Project the gradient along and across the direction
	always_comb begin
		gxdx   = (gsa_pkg::PROD_W)'(smp_s1.grad_x) * (gsa_pkg::PROD_W)'(smp_s1.dir_x);
		gydy   = (gsa_pkg::PROD_W)'(smp_s1.grad_y) * (gsa_pkg::PROD_W)'(smp_s1.dir_y);
		gydx   = (gsa_pkg::PROD_W)'(smp_s1.grad_y) * (gsa_pkg::PROD_W)'(smp_s1.dir_x);
		gxdy   = (gsa_pkg::PROD_W)'(smp_s1.grad_x) * (gsa_pkg::PROD_W)'(smp_s1.dir_y);
		along  = {gxdx[gsa_pkg::PROD_W-1], gxdx} + {gydy[gsa_pkg::PROD_W-1], gydy};
		across = {gydx[gsa_pkg::PROD_W-1], gydx} - {gxdy[gsa_pkg::PROD_W-1], gxdy};
	end

	// Top-left corner is floor(center/16 - side/2); check it against the image
	always_comb begin
		diff_x  = {{2{smp_s1.center_x[gsa_pkg::CTR_W-1]}}, smp_s1.center_x}
			- {11'd0, smp_s1.side, 3'd0};
		diff_y  = {{2{smp_s1.center_y[gsa_pkg::CTR_W-1]}}, smp_s1.center_y}
			- {11'd0, smp_s1.side, 3'd0};
		tl_x    = diff_x[gsa_pkg::CTR_W+1:4];
		tl_y    = diff_y[gsa_pkg::CTR_W+1:4];
		far_x   = {1'b0, tl_x[13:0]} + 15'(smp_s1.side) + 15'd1;
		far_y   = {1'b0, tl_y[13:0]} + 15'(smp_s1.side) + 15'd1;
		side_ok = (smp_s1.side != '0) && (32'(smp_s1.side) <= MAX_SIDE);
		in_window = side_ok && !tl_x[14] && !tl_y[14]
			&& (far_x <= 15'(bounds.image_width))
			&& (far_y <= 15'(bounds.image_height));
	end

	// Hand the projected item to the accumulator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			proj_s2.proj_along  <= along;
			proj_s2.proj_across <= across;
			proj_s2.last        <= smp_s1.last;
			proj_s2.in_image    <= in_window;
		end
	end

endmodule

// File: src/gsa_accum.sv
// ----------------------------------------------------------------------------
// gsa_accum
// Saturating window accumulators and the result register.
// ----------------------------------------------------------------------------
module gsa_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  gsa_pkg::proj_t     proj_s2,
	output logic               take_s2,
	gsa_result_if.source       result_ch
);

	logic [gsa_pkg::SUM_W-1:0] pos_along_q, neg_along_q, pos_across_q, neg_across_q;
	logic [gsa_pkg::SUM_W-1:0] pos_along_d, neg_along_d, pos_across_d, neg_across_d;
	logic [gsa_pkg::PROJ_W-1:0] neg_along_v, neg_across_v;
	logic [gsa_pkg::MAG_W-1:0]  mag_along, mag_across;
	logic                       out_valid_q;

	// Non-last items never wait; a last item waits for a free result slot
	assign take_s2 = valid_s2 && (!proj_s2.last || !out_valid_q || result_ch.ready);

	// Split each projection into sign and magnitude and add it in
	always_comb begin
		neg_along_v  = -proj_s2.proj_along;
		neg_across_v = -proj_s2.proj_across;
		mag_along    = proj_s2.proj_along[gsa_pkg::PROJ_W-1]
			? neg_along_v[gsa_pkg::MAG_W-1:0] : proj_s2.proj_along[gsa_pkg::MAG_W-1:0];
		mag_across   = proj_s2.proj_across[gsa_pkg::PROJ_W-1]
			? neg_across_v[gsa_pkg::MAG_W-1:0] : proj_s2.proj_across[gsa_pkg::MAG_W-1:0];

		pos_along_d  = pos_along_q;
		neg_along_d  = neg_along_q;
		pos_across_d = pos_across_q;
		neg_across_d = neg_across_q;
		if (proj_s2.proj_along[gsa_pkg::PROJ_W-1]) begin
			neg_along_d = gsa_pkg::sat_add(neg_along_q, mag_along);
		end else begin
			pos_along_d = gsa_pkg::sat_add(pos_along_q, mag_along);
		end
		if (proj_s2.proj_across[gsa_pkg::PROJ_W-1]) begin
			neg_across_d = gsa_pkg::sat_add(neg_across_q, mag_across);
		end else begin
			pos_across_d = gsa_pkg::sat_add(pos_across_q, mag_across);
		end
	end

	// Advance the accumulators; clear them after the last item of a window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_along_q  <= '0;
			neg_along_q  <= '0;
			pos_across_q <= '0;
			neg_across_q <= '0;
		end else if (take_s2) begin
			if (proj_s2.last) begin
				pos_along_q  <= '0;
				neg_along_q  <= '0;
				pos_across_q <= '0;
				neg_across_q <= '0;
			end else begin
				pos_along_q  <= pos_along_d;
				neg_along_q  <= neg_along_d;
				pos_across_q <= pos_across_d;
				neg_across_q <= neg_across_d;
			end
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s2 && proj_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && proj_s2.last) begin
			result_ch.sum_pos_along  <= proj_s2.in_image ? pos_along_d  : '0;
			result_ch.sum_neg_along  <= proj_s2.in_image ? neg_along_d  : '0;
			result_ch.sum_pos_across <= proj_s2.in_image ? pos_across_d : '0;
			result_ch.sum_neg_across <= proj_s2.in_image ? neg_across_d : '0;
			result_ch.in_image       <= proj_s2.in_image;
		end
	end

	assign result_ch.valid = out_valid_q;

endmodule
